// ===== rtl/mlil_pkg.sv =====
package mlil_pkg;

  // Filter geometry
  localparam int LEADS       = 12;
  localparam int TAP_SPACING = 5;
  localparam int SAMPLE_BITS = 16;
  localparam int LEAD_BITS   = 4;

  localparam int DELAY_LEN     = 2 * TAP_SPACING;
  localparam int GAIN          = TAP_SPACING * TAP_SPACING;
  localparam int GAIN_BITS     = $clog2(GAIN);
  localparam int ACC_BITS      = SAMPLE_BITS + GAIN_BITS;
  localparam int LEAD_IDX_BITS = (LEADS > 1) ? $clog2(LEADS) : 1;

  // Divide by GAIN as multiply by a rounded-up reciprocal; exact over the accumulator range
  localparam int                RECIP_SHIFT = ACC_BITS + GAIN_BITS;
  localparam longint unsigned   RECIP       = ((64'd1 << RECIP_SHIFT) + GAIN - 1) / GAIN;
  localparam int                RECIP_BITS  = $clog2(RECIP + 1);
  localparam int                PROD_BITS   = ACC_BITS + RECIP_BITS;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Request codes on the input channel
  localparam logic REQ_FILTER = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    OP_FILTER,
    OP_CLEAR,
    OP_IGNORE
  } op_t;

  typedef struct packed {
    op_t                            op;
    logic [LEAD_IDX_BITS-1:0]       idx;
    logic signed [SAMPLE_BITS-1:0]  sample;
  } item_t;

  // Recursion value handed from the state stage to the scaling stage
  typedef struct packed {
    logic                        vld;
    logic signed [ACC_BITS-1:0]  y;
  } acc_res_t;

endpackage

// ===== rtl/mlil_front.sv =====
module mlil_front
  import mlil_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_req_type,
  input  logic [LEAD_BITS-1:0]   in_lead,
  input  logic [SAMPLE_BITS-1:0] in_sample_in,
  input  logic                   q_pop,
  output logic                   q_valid,
  output item_t                  q_item
);

  item_t                cls_item;
  logic                 lead_ok;
  logic                 push;
  logic                 pop;
  item_t                fifo_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;

  // Classify the incoming transaction
  always_comb begin
    lead_ok = 32'(in_lead) < 32'(LEADS);
    if (in_req_type == REQ_CLEAR) begin
      cls_item.op = OP_CLEAR;
    end else if (lead_ok) begin
      cls_item.op = OP_FILTER;
    end else begin
      cls_item.op = OP_IGNORE;
    end
    cls_item.idx    = (cls_item.op == OP_FILTER) ? LEAD_IDX_BITS'(in_lead) : '0;
    cls_item.sample = $signed(in_sample_in);
  end

  // Queue control
  assign in_stall = (cnt_r == QCNT_BITS'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

// ===== rtl/mlil_core.sv =====
module mlil_core
  import mlil_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  logic     q_valid,
  input  item_t    q_item,
  output logic     q_pop,
  output acc_res_t res
);

  typedef struct packed {
    logic [DELAY_LEN-1:0][SAMPLE_BITS-1:0] taps;
    logic signed [ACC_BITS-1:0]            acc;
    logic signed [ACC_BITS-1:0]            acc2;
  } lead_row_t;

  // Per-lead state rows and their valid bits
  lead_row_t                mem_r [LEADS];
  logic [LEADS-1:0]         row_vld_r;

  logic                     s1_vld_r;
  item_t                    s1_item_r;
  logic                     s2_vld_r;
  item_t                    s2_item_r;
  lead_row_t                rd_r;
  logic                     rd_vld_r;

  // Bypass of the write made at the edge the current item was read
  logic                     last_vld_r;
  logic                     last_clr_r;
  logic [LEAD_IDX_BITS-1:0] last_idx_r;
  lead_row_t                last_row_r;

  lead_row_t                cur_row;
  lead_row_t                new_row;
  logic                     last_hit;
  logic signed [ACC_BITS-1:0] x_ext;
  logic signed [ACC_BITS-1:0] d_mid;
  logic signed [ACC_BITS-1:0] d_end;
  logic signed [ACC_BITS-1:0] y;
  logic                     s2_filter;
  logic                     s2_clear;

  assign q_pop     = adv;
  assign s2_filter = s2_vld_r && (s2_item_r.op == OP_FILTER);
  assign s2_clear  = s2_vld_r && (s2_item_r.op == OP_CLEAR);

  // Current state of the lead in stage two
  always_comb begin
    last_hit = last_vld_r && (last_clr_r || (last_idx_r == s2_item_r.idx));
    if (last_hit) begin
      cur_row = last_clr_r ? '0 : last_row_r;
    end else begin
      cur_row = rd_vld_r ? rd_r : '0;
    end
  end

  // Recursion y = 2y1 - y2 + x - 2x[n-S] + x[n-2S]; wraps safely as the result fits
  always_comb begin
    x_ext = ACC_BITS'(s2_item_r.sample);
    d_mid = ACC_BITS'($signed(cur_row.taps[TAP_SPACING-1]));
    d_end = ACC_BITS'($signed(cur_row.taps[DELAY_LEN-1]));
    y     = (cur_row.acc <<< 1) - cur_row.acc2 + x_ext - (d_mid <<< 1) + d_end;
    new_row.taps = {cur_row.taps[DELAY_LEN-2:0], s2_item_r.sample};
    new_row.acc  = y;
    new_row.acc2 = cur_row.acc;
  end

  // Pipeline control, valid bits and the result handed on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      last_vld_r <= 1'b0;
      last_clr_r <= 1'b0;
      row_vld_r  <= '0;
      res.vld    <= 1'b0;
    end else if (adv) begin
      s1_vld_r   <= q_valid;
      s2_vld_r   <= s1_vld_r;
      last_vld_r <= s2_filter || s2_clear;
      last_clr_r <= s2_clear;
      res.vld    <= s2_vld_r;
      res.y      <= s2_filter ? y : '0;
      if (s2_clear) begin
        row_vld_r <= '0;
      end else if (s2_filter) begin
        row_vld_r[s2_item_r.idx] <= 1'b1;
      end
    end
  end

  // Payload registers and state memory
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r  <= q_item;
      s2_item_r  <= s1_item_r;
      rd_r       <= mem_r[s1_item_r.idx];
      rd_vld_r   <= row_vld_r[s1_item_r.idx];
      last_idx_r <= s2_item_r.idx;
      last_row_r <= new_row;
      if (s2_filter) begin
        mem_r[s2_item_r.idx] <= new_row;
      end
    end
  end

  // A clear leaves every lead empty
  assert property (@(posedge clk) disable iff (!rst_n)
    adv && s2_clear |=> row_vld_r == '0)
    else $error("lead state not cleared");

  // An ignored transaction touches no lead state
  assert property (@(posedge clk) disable iff (!rst_n)
    adv && s2_vld_r && (s2_item_r.op == OP_IGNORE) |=> $stable(row_vld_r))
    else $error("ignored transaction changed lead state");

  // A filtered sample leaves its lead valid
  assert property (@(posedge clk) disable iff (!rst_n)
    adv && s2_filter |=> row_vld_r[$past(s2_item_r.idx)])
    else $error("lead row not marked valid after write");

endmodule

// ===== rtl/mlil_scale.sv =====
module mlil_scale
  import mlil_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  acc_res_t                      res,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_filtered
);

  logic                          mag_vld_r;
  logic [ACC_BITS-1:0]           mag_r;
  logic                          mag_neg_r;
  logic                          prod_vld_r;
  logic [PROD_BITS-1:0]          prod_r;
  logic                          prod_neg_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_filtered_r;
  logic [SAMPLE_BITS-1:0]        q_mag;

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;
  assign q_mag        = SAMPLE_BITS'(prod_r >> RECIP_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_vld_r   <= 1'b0;
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      mag_vld_r   <= res.vld;
      prod_vld_r  <= mag_vld_r;
      out_valid_r <= prod_vld_r;
    end
  end

  // Magnitude, reciprocal multiply, then truncation toward zero
  always_ff @(posedge clk) begin
    if (adv) begin
      mag_neg_r      <= res.y[ACC_BITS-1];
      mag_r          <= res.y[ACC_BITS-1] ? ACC_BITS'(-res.y) : ACC_BITS'(res.y);
      prod_neg_r     <= mag_neg_r;
      prod_r         <= PROD_BITS'(mag_r) * PROD_BITS'(RECIP);
      out_filtered_r <= prod_neg_r ? -$signed(q_mag) : $signed(q_mag);
    end
  end

endmodule

// ===== rtl/multi_lead_integer_lowpass_top.sv =====
// Channel-multiplexed integer low-pass, (1-z^-5)^2/(1-z^-1)^2 scaled by 1/25, for
// twelve leads. Each sample transaction names its lead and gets one result, the filtered
// value truncated toward zero; a clear transaction zeroes every lead and returns 0, and a
// lead number of twelve or more is ignored and returns 0. One transaction is taken every
// clock while the queue is not full, and results follow in order. The per-lead state
// (ten past samples and two recursion values) sits in a twelve-row memory with a
// read-modify-write loop closed by a bypass of the previous write, so samples of the same
// lead may arrive back to back. A four-entry queue after the input lets input and output
// stall independently; no clearing pass is needed after reset.
module multi_lead_integer_lowpass_top
  import mlil_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [LEAD_BITS-1:0]          in_lead,
  input  logic [SAMPLE_BITS-1:0]        in_sample_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_filtered
);

  logic     adv;
  logic     q_valid;
  logic     q_pop;
  item_t    q_item;
  acc_res_t res;

  // Back end moves unless a result waits on a stalled output
  assign adv = !(out_valid && out_stall);

  mlil_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_lead      (in_lead),
    .in_sample_in (in_sample_in),
    .q_pop        (q_pop),
    .q_valid      (q_valid),
    .q_item       (q_item)
  );

  mlil_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .res     (res)
  );

  mlil_scale u_scale (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .res          (res),
    .out_valid    (out_valid),
    .out_filtered (out_filtered)
  );

endmodule
